[src/ugtc_pkg.sv]
// Shared types, constants and lookup functions for the calendar/GPS time converter.
package ugtc_pkg;

    localparam int NSTAGE = 6;

    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
    localparam logic [21:0] MS_PER_MIN  = 22'd60000;

    localparam logic signed [21:0] DAY_OFFSET = 22'sd723263;
    localparam logic [16:0] MJD_EPOCH = 17'd44244;
    localparam logic [21:0] B_OFFSET  = 22'd2401538;
    localparam logic [20:0] R_OFFSET  = 21'd878657;
    localparam logic [12:0] C_BASE    = 13'd6695;
    localparam logic [12:0] YEAR_BASE = 13'd4715;

    localparam logic [20:0] K_DIV7     = 21'd1198373;
    localparam logic [21:0] K_DIV_C    = 22'd2351796;
    localparam logic [20:0] K_DIV_HOUR = 21'd1221680;
    localparam logic [17:0] K_DIV_MIN  = 18'd143166;

    typedef enum logic {
        REQ_CAL_TO_GPS = 1'b0,
        REQ_GPS_TO_CAL = 1'b1
    } t_req_type;

    typedef struct packed {
        logic        req_type;
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  cal_hour;
        logic [5:0]  cal_minute;
        logic [15:0] cal_millis;
        logic [12:0] gps_week_in;
        logic [29:0] week_millis_in;
    } t_req;

    typedef struct packed {
        logic [12:0] gps_week_out;
        logic [29:0] week_millis_out;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [15:0] millis_out;
        logic        before_epoch;
    } t_res;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] v;
        logic [NSTAGE-1:0] dir;
    } t_pipe_ctl;

    // Whole days of 30.6001 * n, truncated.
    function automatic logic [8:0] day_off(input logic [4:0] n);
        logic [8:0] r;
        unique case (n)
            5'd0:    r = 9'd0;
            5'd1:    r = 9'd30;
            5'd2:    r = 9'd61;
            5'd3:    r = 9'd91;
            5'd4:    r = 9'd122;
            5'd5:    r = 9'd153;
            5'd6:    r = 9'd183;
            5'd7:    r = 9'd214;
            5'd8:    r = 9'd244;
            5'd9:    r = 9'd275;
            5'd10:   r = 9'd306;
            5'd11:   r = 9'd336;
            5'd12:   r = 9'd367;
            5'd13:   r = 9'd397;
            5'd14:   r = 9'd428;
            5'd15:   r = 9'd459;
            5'd16:   r = 9'd489;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [29:0] ms_of_days(input logic [3:0] n);
        return 30'(n) * 30'(MS_PER_DAY);
    endfunction

endpackage

[src/ugtc_req_if.sv]
// Request channel: valid/ready handshake carrying one conversion request.
interface ugtc_req_if;
    logic          valid;
    logic          ready;
    ugtc_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/ugtc_res_if.sv]
// Result channel: valid/ready handshake carrying one conversion result.
interface ugtc_res_if;
    logic          valid;
    logic          ready;
    ugtc_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/ugtc_pipe_ctl.sv]
// Stage valid flags, per-stage load enables and direction tags of the pipeline.
module ugtc_pipe_ctl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_dir,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output ugtc_pkg::t_pipe_ctl   o_ctl
);
    import ugtc_pkg::*;

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] r_dir;
    logic [NSTAGE-1:0] w_en;

    // A stage loads when empty or when the stage after it moves.
    always_comb begin
        w_en[NSTAGE-1] = !r_v[NSTAGE-1] || i_out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dir[0] <= i_in_dir;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (w_en[k]) begin
                r_dir[k] <= r_dir[k-1];
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NSTAGE-1];
    assign o_ctl.en    = w_en;
    assign o_ctl.v     = r_v;
    assign o_ctl.dir   = r_dir;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_v) && !i_out_ready)
        else $error("input stalled with a free stage or a ready sink");

    a_beat_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v[0] && (r_dir[0] == $past(i_in_dir)))
        else $error("accepted beat not held in first stage");

endmodule

[src/ugtc_cal2gps.sv]
// Calendar date and time of day to GPS week and milliseconds of week.
module ugtc_cal2gps (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ugtc_pkg::t_pipe_ctl i_ctl,
    input  ugtc_pkg::t_req      i_req,
    output logic [12:0]         o_week,
    output logic [29:0]         o_week_millis,
    output logic                o_before_epoch
);
    import ugtc_pkg::*;

    logic               w_low;
    logic signed [12:0] w_ya;
    logic [4:0]         w_m1;
    logic signed [23:0] w_yp;
    logic signed [23:0] w_yq;

    logic signed [21:0] r1_yterm;
    logic [8:0]         r1_mterm;
    logic [4:0]         r1_day;
    logic [26:0]        r1_hp;
    logic [21:0]        r1_mp;
    logic [15:0]        r1_ms;

    logic signed [21:0] r2_days;
    logic [26:0]        r2_tod;

    logic               w_over;
    logic signed [21:0] w_days;
    logic [19:0]        r3_days;
    logic [26:0]        r3_tod;
    logic               r3_neg;

    logic [40:0]        w_qp;
    logic [19:0]        r4_days;
    logic [17:0]        r4_week;
    logic [26:0]        r4_tod;
    logic               r4_neg;

    logic [20:0]        w_rem_full;
    logic [2:0]         w_rem;

    // Treat January and February as months 13 and 14 of the previous year.
    assign w_low = (i_req.cal_month <= 4'd2);
    assign w_ya  = $signed({1'b0, i_req.cal_year}) - (w_low ? 13'sd1 : 13'sd0);
    assign w_m1  = 5'(i_req.cal_month) + (w_low ? 5'd13 : 5'd1);
    assign w_yp  = 24'(w_ya) * 24'sd1461;
    assign w_yq  = w_yp[23] ? ((w_yp + 24'sd3) >>> 2) : (w_yp >>> 2);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r1_yterm <= 22'(w_yq);
            r1_mterm <= day_off(w_m1);
            r1_day   <= i_req.cal_day;
            r1_hp    <= 27'(i_req.cal_hour) * MS_PER_HOUR;
            r1_mp    <= 22'(i_req.cal_minute) * MS_PER_MIN;
            r1_ms    <= i_req.cal_millis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r2_days <= r1_yterm + $signed(22'(r1_mterm)) + $signed(22'(r1_day)) - DAY_OFFSET;
            r2_tod  <= r1_hp + 27'(r1_mp) + 27'(r1_ms);
        end
    end

    // Carry a time of day past midnight into the day count.
    assign w_over = (r2_tod >= MS_PER_DAY);
    assign w_days = r2_days + (w_over ? 22'sd1 : 22'sd0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r3_days <= w_days[19:0];
            r3_tod  <= w_over ? (r2_tod - MS_PER_DAY) : r2_tod;
            r3_neg  <= w_days[21];
        end
    end

    assign w_qp = 41'(r3_days) * 41'(K_DIV7);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r4_days <= r3_days;
            r4_week <= w_qp[40:23];
            r4_tod  <= r3_tod;
            r4_neg  <= r3_neg;
        end
    end

    assign w_rem_full     = 21'(r4_days) - 21'(r4_week) * 21'd7;
    assign w_rem          = w_rem_full[2:0];
    assign o_week         = r4_week[12:0];
    assign o_week_millis  = ms_of_days(4'(w_rem)) + 30'(r4_tod);
    assign o_before_epoch = r4_neg;

    a_tod_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.v[3] |-> r3_tod < MS_PER_DAY)
        else $error("time of day not reduced below one day");

    a_week_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.v[4] && !r4_neg |-> w_rem_full < 21'd7)
        else $error("day of week out of range after week split");

endmodule

[src/ugtc_gps2cal.sv]
// GPS week and milliseconds of week to calendar date and time of day.
module ugtc_gps2cal (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ugtc_pkg::t_pipe_ctl i_ctl,
    input  ugtc_pkg::t_req      i_req,
    output logic [11:0]         o_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day,
    output logic [4:0]          o_hour,
    output logic [5:0]          o_minute,
    output logic [15:0]         o_millis
);
    import ugtc_pkg::*;

    logic [3:0]  w_q;
    logic [16:0] r1_wmjd;
    logic [3:0]  r1_q;
    logic [26:0] r1_msday;

    logic [17:0] w_s;
    logic [40:0] w_hp;
    logic [21:0] r2_b;
    logic [20:0] r2_r;
    logic [26:0] r2_msday;
    logic [4:0]  r2_hour;

    logic [42:0] w_cp;
    logic [12:0] r3_c;
    logic [21:0] r3_b;
    logic [21:0] r3_remh;
    logic [4:0]  r3_hour;

    logic [23:0] w_dd;
    logic [34:0] w_mp;
    logic [8:0]  r4_t;
    logic [12:0] r4_c;
    logic [21:0] r4_remh;
    logic [4:0]  r4_hour;
    logic [5:0]  r4_min;

    logic [4:0]  w_e;
    logic [3:0]  w_month;
    logic [12:0] w_yadj;

    // Whole days held in the millisecond count.
    always_comb begin
        w_q = 4'd0;
        for (int k = 1; k <= 12; k++) begin
            if (i_req.week_millis_in >= ms_of_days(4'(k))) begin
                w_q = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r1_wmjd  <= 17'(i_req.gps_week_in) * 17'd7 + MJD_EPOCH;
            r1_q     <= w_q;
            r1_msday <= 27'(i_req.week_millis_in - ms_of_days(w_q));
        end
    end

    assign w_s  = 18'(r1_wmjd) + 18'(r1_q);
    assign w_hp = 41'(r1_msday[26:7]) * 41'(K_DIV_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r2_b     <= 22'(w_s) + B_OFFSET;
            r2_r     <= 21'(22'(w_s) * 22'd20 - 22'(R_OFFSET));
            r2_msday <= r1_msday;
            r2_hour  <= 5'(w_hp >> 35);
        end
    end

    assign w_cp = 43'(r2_r) * 43'(K_DIV_C);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r3_c    <= C_BASE + 13'(w_cp >> 34);
            r3_b    <= r2_b;
            r3_remh <= 22'(r2_msday - 27'(r2_hour) * MS_PER_HOUR);
            r3_hour <= r2_hour;
        end
    end

    assign w_dd = 24'(r3_c) * 24'd1461;
    assign w_mp = 35'(r3_remh[21:5]) * 35'(K_DIV_MIN);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r4_t    <= 9'(r3_b - 22'(w_dd >> 2));
            r4_c    <= r3_c;
            r4_remh <= r3_remh;
            r4_hour <= r3_hour;
            r4_min  <= 6'(w_mp >> 28);
        end
    end

    // Month index: count of month starts lying below the day of the year.
    always_comb begin
        w_e = 5'd0;
        for (int k = 1; k <= 16; k++) begin
            if (r4_t > day_off(5'(k))) begin
                w_e = 5'(k);
            end
        end
    end

    assign w_month = (w_e >= 5'd14) ? 4'(w_e - 5'd13) : 4'(w_e - 5'd1);

    always_comb begin
        priority if (w_month >= 4'd13) begin
            w_yadj = 13'd2;
        end else if (w_month >= 4'd3) begin
            w_yadj = 13'd1;
        end else begin
            w_yadj = 13'd0;
        end
    end

    assign o_year   = 12'(r4_c - YEAR_BASE - w_yadj);
    assign o_month  = w_month;
    assign o_day    = 5'(r4_t - day_off(w_e));
    assign o_hour   = r4_hour;
    assign o_minute = r4_min;
    assign o_millis = 16'(r4_remh - 22'(r4_min) * MS_PER_MIN);

    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.v[4] |-> (r4_t >= 9'd123) && (r4_t <= 9'd488))
        else $error("day count within year out of range");

    a_hms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.v[4] |-> (r4_hour < 5'd24) && (r4_min < 6'd60))
        else $error("hour or minute out of range");

endmodule

[src/utc_gps_time_conversion.sv]
// Top level: calendar time and GPS week/milliseconds converter, both directions.
// Pipeline: six register stages, from the request register to the result register.
// Throughput: one request per cycle unless a full pipeline waits on a stalled result.
// Stalls hold only the stages behind a waiting result; empty stages keep filling.
// Reset: synchronous, active low; clears all stage valid flags, data registers are not reset.
module utc_gps_time_conversion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ugtc_req_if.sink    i_req,
    ugtc_res_if.source  o_res
);
    import ugtc_pkg::*;

    t_pipe_ctl   ctl;
    t_req        r_req;
    t_res        r_res;
    t_res        n_res;
    logic        w_in_ready;
    logic        w_out_valid;

    logic [12:0] w_week;
    logic [29:0] w_week_millis;
    logic        w_before_epoch;
    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic [4:0]  w_hour;
    logic [5:0]  w_minute;
    logic [15:0] w_millis;

    ugtc_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_dir    (i_req.data.req_type),
        .i_out_ready (o_res.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_ctl       (ctl)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_req <= i_req.data;
        end
    end

    ugtc_cal2gps u_cal2gps (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_req          (r_req),
        .o_week         (w_week),
        .o_week_millis  (w_week_millis),
        .o_before_epoch (w_before_epoch)
    );

    ugtc_gps2cal u_gps2cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_req    (r_req),
        .o_year   (w_year),
        .o_month  (w_month),
        .o_day    (w_day),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_millis (w_millis)
    );

    always_comb begin
        n_res = '0;
        priority if (t_req_type'(ctl.dir[NSTAGE-2]) == REQ_GPS_TO_CAL) begin
            n_res.year_out   = w_year;
            n_res.month_out  = w_month;
            n_res.day_out    = w_day;
            n_res.hour_out   = w_hour;
            n_res.minute_out = w_minute;
            n_res.millis_out = w_millis;
        end else if (w_before_epoch) begin
            n_res.before_epoch = 1'b1;
        end else begin
            n_res.gps_week_out    = w_week;
            n_res.week_millis_out = w_week_millis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[NSTAGE-1]) begin
            r_res <= n_res;
        end
    end

    assign i_req.ready = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = r_res;

endmodule
